/* design/klerp_pkg.sv */
// Shared types and constants for the keyframe position interpolator.
`timescale 1ns / 1ps
`default_nettype none

package klerp_pkg;

  // Keyframe table geometry
  localparam int KEY_DEPTH = 16;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int CNT_W     = $clog2(KEY_DEPTH) + 1;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam logic REG_KEYS_IN_USE = 1'b0;

  // Divider geometry: 32-bit magnitude scaled by 2^16
  localparam int DIV_STEPS = 48;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic              opcode;
    logic [3:0]        key_slot;
    logic [31:0]       key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [3:0]         segment;
  } out_item_t;

  // Axis tag that travels with each multiply through the blend pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] axis;
  } mac_tag_t;

endpackage

`default_nettype wire

/* design/klerp_div.sv */
// Restoring divider: one quotient bit per cycle, 48-bit dividend, 32-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module klerp_div
  import klerp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_STEPS-1:0] dividend,
  input  wire logic [31:0]          divisor,
  output logic                      done,
  output logic [DIV_STEPS-1:0]      quotient
);

  logic                 running_r;
  logic                 done_r;
  logic [DIV_CW-1:0]    cnt_r;
  logic [DIV_STEPS-1:0] dvd_r;
  logic [31:0]          dvs_r;
  logic [31:0]          rem_r;

  logic [32:0] shifted;
  logic [33:0] diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign shifted = {rem_r, dvd_r[DIV_STEPS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (running_r) begin
      if (!diff[33]) begin
        rem_r <= diff[31:0];
        dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

/* design/klerp_mac.sv */
// Per-axis blend pipeline: delta, factor multiply, truncating scale and saturating add.
`timescale 1ns / 1ps
`default_nettype none

module klerp_mac
  import klerp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mac_tag_t            in_tag,
  input  wire logic signed [31:0]  factor,
  input  wire logic signed [31:0]  s_val,
  input  wire logic signed [31:0]  e_val,
  output mac_tag_t                 out_tag,
  output logic signed [31:0]       out_value
);

  mac_tag_t           tag1_r, tag2_r;
  logic signed [32:0] delta_r;
  logic signed [31:0] s1_r, s2_r;
  logic signed [64:0] prod_r;

  logic signed [48:0] step_c;
  logic               corr_c;
  logic [49:0]        sum_c;

  // Advance the axis tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
    end
  end

  // Stage 1: exact end minus start; stage 2: factor times delta
  always_ff @(posedge clk) begin
    delta_r <= 33'(e_val) - 33'(s_val);
    s1_r    <= s_val;
    prod_r  <= 65'(factor) * 65'(delta_r);
    s2_r    <= s1_r;
  end

  // Divide by 2^16 toward zero: floor, plus one for a negative inexact product
  assign step_c = prod_r[64:16];
  assign corr_c = prod_r[64] && (|prod_r[15:0]);
  assign sum_c  = 50'(s2_r) + 50'(step_c) + 50'(corr_c);

  // Clamp to the signed 32-bit range
  always_comb begin
    if (!sum_c[49] && (|sum_c[48:31])) begin
      out_value = 32'sh7FFF_FFFF;
    end else if (sum_c[49] && !(&sum_c[48:31])) begin
      out_value = 32'sh8000_0000;
    end else begin
      out_value = sum_c[31:0];
    end
  end

  assign out_tag = tag2_r;

endmodule

`default_nettype wire

/* design/keyframe_position_lerp_core.sv */
// Keyframe position interpolator: key table, segment scan sequencer and register port.
`timescale 1ns / 1ps
`default_nettype none

// A write item (opcode 0) is stored in the key table at the edge that accepts it and
// leaves busy low, so writes can follow one another every cycle. A query item holds
// busy high until its result appears. With one key in use it returns that key as is;
// otherwise the sequencer scans the key table, a read state and a compare state per
// key, to find the segment, then forms the blend factor with the 48-step restoring
// divider, which is skipped when that segment has zero length, and the three axes
// then share one multiplier. The result is shown for one cycle with out_valid, in the
// first cycle with busy low again, and must be taken then. keys_in_use is written
// through the APB port at address 0; the user must write it only while the block is
// idle, which the block does not enforce. Only its low 5 bits are kept; values 0 and
// above 16 act as 1 and 16.

module keyframe_position_lerp_core
  import klerp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN_RD  = 4'd1;
  localparam logic [3:0] ST_SCAN_CMP = 4'd2;
  localparam logic [3:0] ST_RD0      = 4'd3;
  localparam logic [3:0] ST_RD1      = 4'd4;
  localparam logic [3:0] ST_CAP1     = 4'd5;
  localparam logic [3:0] ST_DIVS     = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_MUL      = 4'd8;
  localparam logic [3:0] ST_DRAIN    = 4'd9;

  logic [3:0]        state_r;
  logic [CNT_W-1:0]  keys_r;
  logic [CNT_W-1:0]  n_r;
  logic [KEY_AW-1:0] idx_r;
  logic [KEY_AW-1:0] seg_r;
  logic              one_r;
  logic [31:0]       q_r;
  logic [31:0]       t0_r;
  logic [95:0]       p0_r, p1_r;
  logic signed [33:0] num_r, dt_r;
  logic              q_neg_r;
  logic signed [31:0] factor_r;
  logic [1:0]        iss_r;
  out_item_t         out_r;
  logic              out_valid_r;

  // Key table: {time, x, y, z}
  logic [127:0]      key_mem [KEY_DEPTH];
  logic [127:0]      rd_data_r;
  logic [KEY_AW-1:0] rd_addr;

  logic              accept;
  logic              cfg_wr;
  logic [CNT_W-1:0]  n_c;
  logic [31:0]       num_abs, dt_abs;
  logic              div_start;
  logic              div_done;
  logic [DIV_STEPS-1:0] div_q;
  logic signed [31:0] factor_c;
  mac_tag_t          mac_in, mac_out;
  logic signed [31:0] mac_s, mac_e, mac_value;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;

  // Clamp the key count to 1..KEY_DEPTH
  always_comb begin
    if (keys_r == '0) begin
      n_c = CNT_W'(1);
    end else if (keys_r > CNT_W'(KEY_DEPTH)) begin
      n_c = CNT_W'(KEY_DEPTH);
    end else begin
      n_c = keys_r;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= CNT_W'(1);
    end else if (cfg_wr && (paddr[2] == REG_KEYS_IN_USE)) begin
      keys_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEYS_IN_USE) ? 32'(keys_r) : '0;

  // Table read address follows the sequencer
  always_comb begin
    case (state_r)
      ST_SCAN_RD: rd_addr = idx_r;
      ST_RD1:     rd_addr = seg_r + 1'b1;
      default:    rd_addr = seg_r;
    endcase
  end

  // Store written keys; read one entry every cycle
  always_ff @(posedge clk) begin
    if (accept && (in_item.opcode == OP_WRITE)) begin
      key_mem[in_item.key_slot] <= {in_item.key_time, in_item.key_x,
                                    in_item.key_y, in_item.key_z};
    end
    rd_data_r <= key_mem[rd_addr];
  end

  // Magnitudes for the sign-magnitude divide; both fit in 32 bits
  assign num_abs   = num_r[33] ? 32'(-num_r) : 32'(num_r);
  assign dt_abs    = dt_r[33] ? 32'(-dt_r) : 32'(dt_r);
  assign div_start = (state_r == ST_DIVS) && (dt_r != '0);

  klerp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({num_abs, 16'h0000}),
    .divisor  (dt_abs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Apply the sign and clamp the quotient to signed 32 bits
  always_comb begin
    if (!q_neg_r) begin
      if (|div_q[DIV_STEPS-1:31]) begin
        factor_c = 32'sh7FFF_FFFF;
      end else begin
        factor_c = {1'b0, div_q[30:0]};
      end
    end else begin
      if ((|div_q[DIV_STEPS-1:32]) || (div_q[31] && (|div_q[30:0]))) begin
        factor_c = 32'sh8000_0000;
      end else begin
        factor_c = -div_q[31:0];
      end
    end
  end

  // Feed one axis per cycle into the blend pipeline
  always_comb begin
    mac_in.valid = (state_r == ST_MUL);
    mac_in.axis  = iss_r;
    case (iss_r)
      2'd0:    begin mac_s = p0_r[95:64]; mac_e = p1_r[95:64]; end
      2'd1:    begin mac_s = p0_r[63:32]; mac_e = p1_r[63:32]; end
      default: begin mac_s = p0_r[31:0];  mac_e = p1_r[31:0];  end
    endcase
  end

  klerp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (mac_in),
    .factor    (factor_r),
    .s_val     (mac_s),
    .e_val     (mac_e),
    .out_tag   (mac_out),
    .out_value (mac_value)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_item.opcode == OP_QUERY)) begin
            state_r <= (n_c == CNT_W'(1)) ? ST_RD0 : ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          state_r <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if ((q_r < rd_data_r[127:96]) || ((CNT_W'(idx_r) + 1'b1) >= n_r)) begin
            state_r <= ST_RD0;
          end else begin
            state_r <= ST_SCAN_RD;
          end
        end
        ST_RD0: begin
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          if (one_r) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_CAP1;
          end
        end
        ST_CAP1: begin
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          state_r <= (dt_r == '0) ? ST_MUL : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (iss_r == 2'd2) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_out.valid && (mac_out.axis == 2'd2)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q_r   <= in_item.query_time;
        n_r   <= n_c;
        idx_r <= KEY_AW'(1);
        seg_r <= '0;
        one_r <= (n_c == CNT_W'(1));
        iss_r <= '0;
      end
      ST_SCAN_CMP: begin
        if (q_r < rd_data_r[127:96]) begin
          seg_r <= idx_r - 1'b1;
        end else if ((CNT_W'(idx_r) + 1'b1) >= n_r) begin
          seg_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_RD1: begin
        t0_r <= rd_data_r[127:96];
        p0_r <= rd_data_r[95:0];
        if (one_r) begin
          out_r.pos_x   <= rd_data_r[95:64];
          out_r.pos_y   <= rd_data_r[63:32];
          out_r.pos_z   <= rd_data_r[31:0];
          out_r.segment <= 4'(seg_r);
        end
      end
      ST_CAP1: begin
        p1_r  <= rd_data_r[95:0];
        num_r <= $signed({2'b00, q_r}) - $signed({2'b00, t0_r});
        dt_r  <= $signed({2'b00, rd_data_r[127:96]}) - $signed({2'b00, t0_r});
      end
      ST_DIVS: begin
        q_neg_r  <= num_r[33] ^ dt_r[33];
        factor_r <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          factor_r <= factor_c;
        end
      end
      ST_MUL: begin
        iss_r <= iss_r + 1'b1;
      end
      default: begin
      end
    endcase

    // Collect blended axes as they leave the pipeline
    if (mac_out.valid) begin
      case (mac_out.axis)
        2'd0:    out_r.pos_x <= mac_value;
        2'd1:    out_r.pos_y <= mac_value;
        default: begin
          out_r.pos_z   <= mac_value;
          out_r.segment <= 4'(seg_r);
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

/* design/klerp_chk.sv */
// Port-level checker for the keyframe position interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module klerp_chk
  import klerp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_valid
);

  // A result strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted query always occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.opcode == OP_QUERY)) |=> busy)
    else $error("query transfer did not raise busy");

  // An accepted key write completes at once
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.opcode == OP_WRITE)) |=> !busy)
    else $error("key write transfer left the block busy");

  // A query ends only with its result
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result transfer");

endmodule

bind keyframe_position_lerp_core klerp_chk u_klerp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

`default_nettype wire
